FILE: hw/rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and helpers for the odometry integrator.
// ----------------------------------------------------------------------------
package odo_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CHAIN_LEN     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int STAGE_W       = 5;
   localparam int CORD_W        = 33;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN    = 33'sd652032874;
   localparam logic signed [62:0]       INV_TWO_PI_Q32 = 63'sd683565276;

   localparam logic [15:0] RADIUS_RESET = 16'd2163;
   localparam logic [15:0] INV_SEP_RESET = 16'd1600;
   localparam logic [15:0] DT_RESET     = 16'd655;

   localparam logic [1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [1:0] CSR_INV_SEP      = 2'd1;
   localparam logic [1:0] CSR_STEP_TIME    = 2'd2;

   localparam logic OP_INTEGRATE = 1'b0;
   localparam logic OP_READBACK  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] left_wheel_speed;
      logic signed [15:0] right_wheel_speed;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic        [31:0] heading;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [CORD_W-1:0] z;
   } cordic_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL1 = 8'b0000_0010,
      ST_MUL2 = 8'b0000_0100,
      ST_MUL3 = 8'b0000_1000,
      ST_WAIT = 8'b0001_0000,
      ST_MUL4 = 8'b0010_0000,
      ST_MUL5 = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   function automatic logic signed [CORD_W-1:0] atan_turns(input logic [STAGE_W-1:0] idx);
      logic signed [CORD_W-1:0] a;
      unique case (idx)
         5'd0:  a = 33'sh020000000;
         5'd1:  a = 33'sh012E4051D;
         5'd2:  a = 33'sh009FB385B;
         5'd3:  a = 33'sh0051111D4;
         5'd4:  a = 33'sh0028B0D43;
         5'd5:  a = 33'sh00145D7E1;
         5'd6:  a = 33'sh000A2F61E;
         5'd7:  a = 33'sh000517C55;
         5'd8:  a = 33'sh00028BE53;
         5'd9:  a = 33'sh000145F2E;
         5'd10: a = 33'sh0000A2F98;
         5'd11: a = 33'sh0000517CC;
         5'd12: a = 33'sh000028BE6;
         5'd13: a = 33'sh0000145F3;
         5'd14: a = 33'sh00000A2F9;
         5'd15: a = 33'sh00000517C;
         5'd16: a = 33'sh0000028BE;
         5'd17: a = 33'sh00000145F;
         5'd18: a = 33'sh000000A2F;
         5'd19: a = 33'sh000000517;
         5'd20: a = 33'sh00000028B;
         5'd21: a = 33'sh000000145;
         5'd22: a = 33'sh0000000A2;
         5'd23: a = 33'sh000000051;
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/odo_cordic_cell.sv
// ----------------------------------------------------------------------------
// odo_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered toward the next cell.
// ----------------------------------------------------------------------------
module odo_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [odo_pkg::STAGE_W-1:0]  stage,
   input  odo_pkg::cordic_type          prev_cell,
   output odo_pkg::cordic_type          next_cell
);
   import odo_pkg::*;

   cordic_type               data_ff;
   cordic_type               data_in;
   logic signed [CORD_W-1:0] dx;
   logic signed [CORD_W-1:0] dy;
   logic signed [CORD_W-1:0] angle;

   always_comb begin
      dx    = prev_cell.y >>> stage;
      dy    = prev_cell.x >>> stage;
      angle = atan_turns(stage);
      data_in.valid = prev_cell.valid;
      if (!prev_cell.z[CORD_W-1]) begin
         data_in.x = prev_cell.x - dx;
         data_in.y = prev_cell.y + dy;
         data_in.z = prev_cell.z - angle;
      end else begin
         data_in.x = prev_cell.x + dx;
         data_in.y = prev_cell.y - dy;
         data_in.z = prev_cell.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      data_ff.x <= data_in.x;
      data_ff.y <= data_in.y;
      data_ff.z <= data_in.z;
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
   end

   assign next_cell = data_ff;

endmodule

FILE: hw/rtl/diff_drive_odometry_integrator_core.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_core
// Differential-drive odometry with Euler integration of x, y and heading.
// ----------------------------------------------------------------------------
// Requests carry an opcode and the left and right wheel speeds on a
// valid/ready channel; each request gives exactly one response on the
// rsp_ channel. Opcode integrate advances the pose and reports pose and
// velocity; opcode readback reports the scaled velocity and keeps the pose.
// The csr_ port writes wheel radius, inverse separation and step time;
// write only while no request is in flight.
// The heading's cos/sin ripple through the row of CORDIC cells while
// the multiply steps MUL1 to MUL3 run; MUL4 and MUL5 follow the row.
// One request is in flight at a time: the next request is taken only
// once the last one has moved into the output register. A stalled
// receiver holds the result there, and the next request is still taken
// and worked on; it waits at its last step until the register frees.
// Reset clears the pose and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry_integrator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  odo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output odo_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import odo_pkg::*;

   state_type state_ff, state_in;
   logic [15:0] rad_ff, inv_ff, dt_ff;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] head_ff, head_in;
   logic op_ff, op_in, fold_ff, fold_in;
   logic signed [16:0] sum_ff, sum_in, diff_ff, diff_in;
   logic signed [33:0] psum_ff, psum_in, pdiff_ff, pdiff_in, rate_ff, rate_in;
   logic signed [46:0] turns_ff, turns_in;
   logic signed [CORD_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [28:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [30:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0] dh_ff, dh_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept, out_free;
   logic signed [16:0] rad_s, inv_s, dt_s;
   logic signed [50:0] rate_prod;
   logic signed [31:0] wsat;
   logic signed [62:0] turns_prod;
   logic signed [24:0] speed;
   logic signed [58:0] vx_prod, vy_prod;
   logic signed [46:0] dx_prod, dy_prod;
   logic signed [63:0] dh_prod;
   logic signed [32:0] vx5, vy5;
   logic signed [37:0] rate5;
   logic [31:0] angle;

   cordic_type link [CHAIN_LEN+1];

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rad_s = $signed({1'b0, rad_ff});
   assign inv_s = $signed({1'b0, inv_ff});
   assign dt_s  = $signed({1'b0, dt_ff});

   // fold the heading by half a turn into the right half plane
   assign angle         = {head_ff[31] ^ (head_ff[31] ^ head_ff[30]), head_ff[30:0]};
   assign link[0].valid = accept;
   assign link[0].x     = CORDIC_GAIN;
   assign link[0].y     = '0;
   assign link[0].z     = CORD_W'($signed(angle));

   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
      odo_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage     (STAGE_W'(g)),
         .prev_cell (link[g]),
         .next_cell (link[g+1])
      );
   end

   always_comb begin
      rate_prod  = 51'(pdiff_ff) * 51'(inv_s);
      wsat       = sat32(64'(rate_ff));
      turns_prod = 63'(wsat) * INV_TWO_PI_Q32;
      speed      = 25'(psum_ff >>> 9);
      vx_prod    = 59'(speed) * 59'(cos_ff);
      vy_prod    = 59'(speed) * 59'(sin_ff);
      dx_prod    = 47'(dt_s) * 47'(vx_ff);
      dy_prod    = 47'(dt_s) * 47'(vy_ff);
      dh_prod    = 64'(turns_ff) * 64'(dt_s);
      vx5        = 33'(vx_ff) + (33'(vx_ff) <<< 2);
      vy5        = 33'(vy_ff) + (33'(vy_ff) <<< 2);
      rate5      = 38'(rate_ff) + (38'(rate_ff) <<< 2);
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; head_in = head_ff;
      op_in = op_ff; fold_in = fold_ff;
      sum_in = sum_ff; diff_in = diff_ff;
      psum_in = psum_ff; pdiff_in = pdiff_ff; rate_in = rate_ff; turns_in = turns_ff;
      cos_in = cos_ff; sin_in = sin_ff;
      vx_in = vx_ff; vy_in = vy_ff;
      dx_in = dx_ff; dy_in = dy_ff; dh_in = dh_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               fold_in  = head_ff[31] ^ head_ff[30];
               sum_in   = 17'(req_data.right_wheel_speed) + 17'(req_data.left_wheel_speed);
               diff_in  = 17'(req_data.right_wheel_speed) - 17'(req_data.left_wheel_speed);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            psum_in  = 34'(sum_ff) * 34'(rad_s);
            pdiff_in = 34'(diff_ff) * 34'(rad_s);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            rate_in  = 34'(rate_prod >>> 17);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            turns_in = 47'(turns_prod >>> 16);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (link[CHAIN_LEN].valid) begin
               cos_in   = fold_ff ? -link[CHAIN_LEN].x : link[CHAIN_LEN].x;
               sin_in   = fold_ff ? -link[CHAIN_LEN].y : link[CHAIN_LEN].y;
               state_in = ST_MUL4;
            end
         end
         ST_MUL4: begin
            vx_in    = 29'(vx_prod >>> 30);
            vy_in    = 29'(vy_prod >>> 30);
            state_in = ST_MUL5;
         end
         ST_MUL5: begin
            dx_in    = 31'(dx_prod >>> 16);
            dy_in    = 31'(dy_prod >>> 16);
            dh_in    = 32'(dh_prod >>> 16);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register frees
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_INTEGRATE) begin
                  x_in    = sat32(64'(x_ff) + 64'(dx_ff));
                  y_in    = sat32(64'(y_ff) + 64'(dy_ff));
                  head_in = head_ff + dh_ff;
                  rsp_in.pos_x    = x_in;
                  rsp_in.pos_y    = y_in;
                  rsp_in.heading  = head_in;
                  rsp_in.vel_x    = 32'(vx_ff);
                  rsp_in.vel_y    = 32'(vy_ff);
                  rsp_in.yaw_rate = wsat;
               end else begin
                  rsp_in.pos_x    = x_ff;
                  rsp_in.pos_y    = y_ff;
                  rsp_in.heading  = head_ff;
                  rsp_in.vel_x    = sat32(64'(vx5 >>> 1));
                  rsp_in.vel_y    = sat32(64'(vy5 >>> 1));
                  rsp_in.yaw_rate = sat32(-64'(rate5 >>> 1));
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; fold_ff <= fold_in;
      sum_ff <= sum_in; diff_ff <= diff_in;
      psum_ff <= psum_in; pdiff_ff <= pdiff_in; rate_ff <= rate_in; turns_ff <= turns_in;
      cos_ff <= cos_in; sin_ff <= sin_in;
      vx_ff <= vx_in; vy_ff <= vy_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dh_ff <= dh_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         rad_ff       <= RADIUS_RESET;
         inv_ff       <= INV_SEP_RESET;
         dt_ff        <= DT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WHEEL_RADIUS: rad_ff <= csr_wdata;
               CSR_INV_SEP:      inv_ff <= csr_wdata;
               CSR_STEP_TIME:    dt_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/odo_checker.sv
// ----------------------------------------------------------------------------
// odo_checker
// Port-level checks for the odometry integrator core.
// ----------------------------------------------------------------------------
module odo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input odo_pkg::rsp_type rsp_data
);

   // one request in flight: busy right after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // no response rises right behind a request: the multiply steps and the CORDIC row lie between
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind diff_drive_odometry_integrator_core odo_checker u_odo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
